@@ rtl/streaming_inversion_counter_top_macros.svh @@
// Assertion macros shared by the checker of the streaming inversion counter.
// Depends on nothing; included by the checker file.
`ifndef STREAMING_INVERSION_COUNTER_TOP_MACROS_SVH
`define STREAMING_INVERSION_COUNTER_TOP_MACROS_SVH

// Condition a holds in the same cycle as c.
`define SIC_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("sic assertion failed");

// Condition a is followed by c in the next cycle.
`define SIC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("sic assertion failed");

`endif

@@ rtl/sic_pkg.sv @@
// Package of the streaming inversion counter: widths, defaults and the
// control record that travels down the row of compare cells. No dependencies.
package sic_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int VALUE_W       = 32;
    localparam int NEW_W         = 10;
    localparam int TOTAL_W       = 19;

    localparam logic [NEW_W-1:0]   NEW_MAX   = {NEW_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic valid;
        logic last;
        logic ovf;
    } t_ctrl;

endpackage

@@ rtl/sic_cell.sv @@
// One compare cell of the inversion counter row: holds one stored value,
// counts it against each passing item and stores the item at its own position.
// Depends on sic_pkg.
module sic_cell
    import sic_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int POS       = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  t_ctrl                     i_ctrl,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] i_idx,
    input  logic [$clog2(MAX_ITEMS)-1:0]   i_part,
    output t_ctrl                     o_ctrl,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [$clog2(MAX_ITEMS+1)-1:0] o_idx,
    output logic [$clog2(MAX_ITEMS)-1:0]   o_part
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = $clog2(MAX_ITEMS);
    localparam logic [CW-1:0] POS_C = CW'(POS);

    logic signed [VALUE_W-1:0] r_stored;
    t_ctrl                     r_ctrl;
    logic signed [VALUE_W-1:0] r_value;
    logic [CW-1:0]             r_idx;
    logic [PW-1:0]             r_part;
    logic                      w_live;
    logic                      w_hit;
    logic                      w_store;

    assign w_live  = i_ctrl.valid && !i_ctrl.ovf;
    assign w_hit   = w_live && (POS_C < i_idx) && (r_stored > i_value);
    assign w_store = i_adv && w_live && (i_idx == POS_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_adv) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_value <= i_value;
            r_idx   <= i_idx;
            r_part  <= i_part + PW'(w_hit);
        end
        if (w_store) begin
            r_stored <= i_value;
        end
    end

    assign o_ctrl  = r_ctrl;
    assign o_value = r_value;
    assign o_idx   = r_idx;
    assign o_part  = r_part;

endmodule

@@ rtl/sic_tail.sv @@
// Output stage of the inversion counter: keeps the running total and the
// overflow mark of the sequence and holds the result item. Depends on sic_pkg.
module sic_tail
    import sic_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  t_ctrl                        i_ctrl,
    input  logic [$clog2(MAX_ITEMS)-1:0] i_part,
    output logic                         o_valid,
    output logic [NEW_W-1:0]             o_new_inversions,
    output logic [TOTAL_W-1:0]           o_running_total,
    output logic                         o_is_last,
    output logic                         o_overflow
);

    localparam int TW = $clog2(MAX_ITEMS * (MAX_ITEMS - 1) / 2 + 1);
    localparam int SW = (TW > TOTAL_W + 1) ? TW : TOTAL_W + 1;

    logic [SW-1:0]      r_sum;
    logic               r_ovf_seen;
    logic               r_valid;
    logic [NEW_W-1:0]   r_new;
    logic [TOTAL_W-1:0] r_total;
    logic               r_last;
    logic               r_ovf;
    logic [SW-1:0]      w_part;
    logic [SW-1:0]      n_sum;
    logic               n_ovf;

    assign w_part = SW'(i_part);
    assign n_sum  = r_sum + w_part;
    assign n_ovf  = r_ovf_seen | i_ctrl.ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sum      <= '0;
            r_ovf_seen <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_ctrl.valid;
            if (i_ctrl.valid) begin
                r_sum      <= i_ctrl.last ? '0 : n_sum;
                r_ovf_seen <= i_ctrl.last ? 1'b0 : n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctrl.valid) begin
            r_new   <= (w_part > SW'(NEW_MAX)) ? NEW_MAX : NEW_W'(w_part);
            r_total <= (n_sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(n_sum);
            r_last  <= i_ctrl.last;
            r_ovf   <= n_ovf;
        end
    end

    assign o_valid          = r_valid;
    assign o_new_inversions = r_new;
    assign o_running_total  = r_total;
    assign o_is_last        = r_last;
    assign o_overflow       = r_ovf;

endmodule

@@ rtl/streaming_inversion_counter_top.sv @@
// Top level of the streaming inversion counter: position counter, a row of
// MAX_ITEMS compare cells and the output stage. Depends on sic_pkg, sic_cell, sic_tail.
//
// Usage: values of a sequence enter on the input channel (i_valid, o_stall,
// i_value, i_last), one item per cycle while o_stall is low. Each item gives
// one result item on the output channel (o_valid, i_stall) with the count of
// earlier values of the sequence that are strictly greater, the running total,
// the last mark and the overflow mark. The item marked last ends the sequence.
// Every item walks the row of compare cells, one cell per cycle while the row
// is not held, and is stored in the cell of its own position; it is registered
// in each cell and then in the output stage on its way to the result.
// Items beyond MAX_ITEMS in a sequence pass through the row without being
// stored or counted and raise the overflow mark until the sequence ends.
// When the receiver stalls a waiting result, the whole row holds and o_stall
// rises in the same cycle. Reset empties the row and starts a new sequence;
// the stored values need no clearing.
module streaming_inversion_counter_top
    import sic_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [NEW_W-1:0]          o_new_inversions,
    output logic [TOTAL_W-1:0]        o_running_total,
    output logic                      o_is_last,
    output logic                      o_overflow
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = $clog2(MAX_ITEMS);
    localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

    logic [CW-1:0]             r_count;
    logic                      w_adv;
    logic                      w_accept;
    logic                      w_full;
    t_ctrl                     w_ctrl  [0:MAX_ITEMS];
    logic signed [VALUE_W-1:0] w_value [0:MAX_ITEMS];
    logic [CW-1:0]             w_idx   [0:MAX_ITEMS];
    logic [PW-1:0]             w_part  [0:MAX_ITEMS];

    assign w_adv    = !o_valid || !i_stall;
    assign o_stall  = !w_adv;
    assign w_accept = i_valid && w_adv;
    assign w_full   = (r_count == FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            if (i_last) begin
                r_count <= '0;
            end else if (!w_full) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    assign w_ctrl[0]  = '{valid: i_valid, last: i_last, ovf: w_full};
    assign w_value[0] = i_value;
    assign w_idx[0]   = r_count;
    assign w_part[0]  = '0;

    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        sic_cell #(
            .MAX_ITEMS (MAX_ITEMS),
            .POS       (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctrl  (w_ctrl[k]),
            .i_value (w_value[k]),
            .i_idx   (w_idx[k]),
            .i_part  (w_part[k]),
            .o_ctrl  (w_ctrl[k+1]),
            .o_value (w_value[k+1]),
            .o_idx   (w_idx[k+1]),
            .o_part  (w_part[k+1])
        );
    end

    sic_tail #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_tail (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_ctrl           (w_ctrl[MAX_ITEMS]),
        .i_part           (w_part[MAX_ITEMS]),
        .o_valid          (o_valid),
        .o_new_inversions (o_new_inversions),
        .o_running_total  (o_running_total),
        .o_is_last        (o_is_last),
        .o_overflow       (o_overflow)
    );

endmodule

@@ rtl/sic_checker.sv @@
// Port-level checker of the streaming inversion counter and its bind to the
// top level. Depends on sic_pkg and streaming_inversion_counter_top_macros.svh.
`include "streaming_inversion_counter_top_macros.svh"

module sic_checker
    import sic_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [NEW_W-1:0]   o_new_inversions,
    input logic [TOTAL_W-1:0] o_running_total,
    input logic               o_is_last,
    input logic               o_overflow
);

    `SIC_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `SIC_ASSERT_NEXT(a_total_holds, i_clk, i_rst_n, o_valid && i_stall, $stable(o_running_total))
    `SIC_ASSERT_SAME(a_new_le_total, i_clk, i_rst_n, o_valid,
        o_new_inversions <= 10'(o_running_total) || o_running_total >= 19'(NEW_MAX))
    `SIC_ASSERT_SAME(a_ovf_no_count, i_clk, i_rst_n, o_valid && o_overflow, o_new_inversions == '0)
    `SIC_ASSERT_NEXT(a_fresh_seq, i_clk, i_rst_n, o_valid && o_is_last && !i_stall,
        !o_valid || (!o_overflow && o_running_total == 19'(o_new_inversions)))

endmodule

bind streaming_inversion_counter_top sic_checker u_sic_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_new_inversions (o_new_inversions),
    .o_running_total  (o_running_total),
    .o_is_last        (o_is_last),
    .o_overflow       (o_overflow)
);
